/* rtl/fdm_pkg.sv */
// Shared types and constants for the frame difference metrics block.
// Used by every module of the block; depends on nothing.
package fdm_pkg;

	localparam int MAX_FRAME_PIXELS = 65536;

	localparam int PIX_W   = 24;
	localparam int CHAN_W  = 8;
	localparam int DIFF_W  = 32;
	localparam int CNT_W   = 17;
	localparam int ABS_W   = 26;
	localparam int SQ_W    = 34;
	localparam int RATIO_W = 17;
	localparam int Q8_W    = 16;

	localparam int RATIO_SHIFT = 16;
	localparam int MEAN_SHIFT  = 8;
	localparam int RMS_SHIFT   = 16;

	localparam int DIV_NUM_W = SQ_W + RMS_SHIFT;
	localparam int DIV_DEN_W = CNT_W + 2;
	localparam int DIV_QUO_W = 32;

	localparam int ROOT_W = Q8_W;
	localparam int RAD_W  = 2 * ROOT_W;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RATIO = 5'b00010,
		ST_MEAN  = 5'b00100,
		ST_RMS   = 5'b01000,
		ST_ROOT  = 5'b10000
	} fdm_state_t;

	typedef enum logic [1:0] {
		DIV_RATIO = 2'd0,
		DIV_MEAN  = 2'd1,
		DIV_RMS   = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     pix_take;
		logic     div_start;
		div_sel_t div_sel;
		logic     root_start;
		logic     frame_load;
	} fdm_cmd_t;

	typedef struct packed {
		logic div_done;
		logic root_done;
	} fdm_stat_t;

endpackage

/* rtl/fdm_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on fdm_pkg for operand widths.
module fdm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [fdm_pkg::DIV_NUM_W-1:0]  num,
	input  logic [fdm_pkg::DIV_DEN_W-1:0]  den,
	output logic [fdm_pkg::DIV_QUO_W-1:0]  quo,
	output logic                           done
);

	localparam int NUM_W = fdm_pkg::DIV_NUM_W;
	localparam int DEN_W = fdm_pkg::DIV_DEN_W;
	localparam int QUO_W = fdm_pkg::DIV_QUO_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic             busy;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   trial;
	logic             qbit;

	assign busy    = cnt_q != '0;
	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign qbit    = shifted >= {1'b0, den_q};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

/* rtl/fdm_sqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on fdm_pkg for radicand and root widths.
module fdm_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fdm_pkg::RAD_W-1:0]   rad,
	output logic [fdm_pkg::ROOT_W-1:0]  root,
	output logic                        done
);

	localparam int RAD_W  = fdm_pkg::RAD_W;
	localparam int ROOT_W = fdm_pkg::ROOT_W;

	logic [RAD_W-1:0] v_q;
	logic [RAD_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic             done_q;

	logic             busy;
	logic [RAD_W:0]   trial;
	logic             fits;

	assign busy  = bit_q != '0;
	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign fits  = {1'b0, v_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (bit_q == RAD_W'(1));
			if (start) begin
				bit_q <= RAD_W'(1) << (RAD_W - 2);
			end else if (busy) begin
				bit_q <= bit_q >> 2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= rad;
			res_q <= '0;
		end else if (busy) begin
			if (fits) begin
				v_q   <= v_q - trial[RAD_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign root = res_q[ROOT_W-1:0];
	assign done = done_q;

endmodule

/* rtl/fdm_ctrl.sv */
// Controller state machine: input/output handshake and end-of-frame sequencing.
// Depends on fdm_pkg for state, command and status types.
module fdm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                last_of_frame,
	input  logic                out_ready,
	input  fdm_pkg::fdm_stat_t  stat,
	output logic                in_ready,
	output logic                out_valid,
	output fdm_pkg::fdm_cmd_t   cmd
);

	fdm_pkg::fdm_state_t state_q, state_d;
	logic                go_q, go_d;
	logic                out_valid_q;
	logic                rdy;

	always_comb begin
		state_d        = state_q;
		go_d           = go_q;
		rdy            = 1'b0;
		cmd            = '0;
		cmd.div_sel    = fdm_pkg::DIV_RATIO;
		case (state_q)
			fdm_pkg::ST_IDLE: begin
				rdy          = !out_valid_q || out_ready;
				cmd.pix_take = in_valid && rdy;
				if (cmd.pix_take && last_of_frame) begin
					state_d = fdm_pkg::ST_RATIO;
					go_d    = 1'b1;
				end
			end
			fdm_pkg::ST_RATIO: begin
				cmd.div_sel   = fdm_pkg::DIV_RATIO;
				cmd.div_start = go_q;
				go_d          = 1'b0;
				if (stat.div_done) begin
					state_d = fdm_pkg::ST_MEAN;
					go_d    = 1'b1;
				end
			end
			fdm_pkg::ST_MEAN: begin
				cmd.div_sel   = fdm_pkg::DIV_MEAN;
				cmd.div_start = go_q;
				go_d          = 1'b0;
				if (stat.div_done) begin
					state_d = fdm_pkg::ST_RMS;
					go_d    = 1'b1;
				end
			end
			fdm_pkg::ST_RMS: begin
				cmd.div_sel   = fdm_pkg::DIV_RMS;
				cmd.div_start = go_q;
				go_d          = 1'b0;
				if (stat.div_done) begin
					state_d = fdm_pkg::ST_ROOT;
					go_d    = 1'b1;
				end
			end
			fdm_pkg::ST_ROOT: begin
				cmd.div_sel    = fdm_pkg::DIV_RMS;
				cmd.root_start = go_q;
				go_d           = 1'b0;
				if (stat.root_done) begin
					cmd.frame_load = 1'b1;
					state_d        = fdm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fdm_pkg::ST_IDLE;
				go_d    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fdm_pkg::ST_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
			if ((cmd.pix_take && !last_of_frame) || cmd.frame_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = rdy;
	assign out_valid = out_valid_q;

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != fdm_pkg::ST_IDLE) |-> !in_ready)
		else $error("input ready outside idle state");

	a_last_starts_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_of_frame) |=> (state_q == fdm_pkg::ST_RATIO) && go_q)
		else $error("last pixel did not start end-of-frame sequence");

	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_start || cmd.root_start) |=> !(cmd.div_start || cmd.root_start))
		else $error("unit start held longer than one cycle");

	a_out_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past((cmd.pix_take && !last_of_frame) || cmd.frame_load))
		else $error("output valid raised without a load");

endmodule

/* rtl/fdm_datapath.sv */
// Datapath: per-pixel differences, frame accumulators, quotient units, output registers.
// Depends on fdm_pkg, fdm_div and fdm_sqrt.
module fdm_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fdm_pkg::fdm_cmd_t              cmd,
	input  logic [fdm_pkg::PIX_W-1:0]      actual_pixel,
	input  logic [fdm_pkg::PIX_W-1:0]      reference_pixel,
	input  logic                           last_of_frame,
	output fdm_pkg::fdm_stat_t             stat,
	output logic [fdm_pkg::DIFF_W-1:0]     delta_argb,
	output logic                           frame_done,
	output logic [fdm_pkg::CNT_W-1:0]      pixel_total,
	output logic [fdm_pkg::CNT_W-1:0]      mismatch_count,
	output logic [fdm_pkg::CHAN_W-1:0]     peak_delta,
	output logic [fdm_pkg::ABS_W-1:0]      abs_diff_sum,
	output logic [fdm_pkg::SQ_W-1:0]       sq_diff_sum,
	output logic [fdm_pkg::RATIO_W-1:0]    mismatch_ratio_q16,
	output logic [fdm_pkg::Q8_W-1:0]       mean_abs_diff_q8,
	output logic [fdm_pkg::Q8_W-1:0]       rmse_q8
);

	localparam int CHAN_W  = fdm_pkg::CHAN_W;
	localparam int CNT_W   = fdm_pkg::CNT_W;
	localparam int ABS_W   = fdm_pkg::ABS_W;
	localparam int SQ_W    = fdm_pkg::SQ_W;
	localparam int NUM_W   = fdm_pkg::DIV_NUM_W;
	localparam int DEN_W   = fdm_pkg::DIV_DEN_W;
	localparam int PSUM_W  = CHAN_W + 2;
	localparam int PSQ_W   = 2 * CHAN_W + 2;

	function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic [CHAN_W-1:0]   dr, dg, db, m1, m2;
	logic [2*CHAN_W-1:0] sq_r, sq_g, sq_b;
	logic [PSUM_W-1:0]   px_sum;
	logic [PSQ_W-1:0]    px_sq;
	logic                room;

	logic [CNT_W-1:0]    pix_cnt_q;
	logic [CNT_W-1:0]    mis_cnt_q;
	logic [CHAN_W-1:0]   max_q;
	logic [ABS_W-1:0]    abs_acc_q;
	logic [SQ_W-1:0]     sq_acc_q;

	logic [fdm_pkg::RATIO_W-1:0] ratio_q;
	logic [fdm_pkg::Q8_W-1:0]    mean_q;

	logic [NUM_W-1:0]              div_num;
	logic [DEN_W-1:0]              n3;
	logic [DEN_W-1:0]              div_den;
	logic [fdm_pkg::DIV_QUO_W-1:0] div_quo;
	logic                          div_done;
	logic [fdm_pkg::ROOT_W-1:0]    root;
	logic                          root_done;

	logic [fdm_pkg::DIFF_W-1:0]  delta_argb_q;
	logic                        frame_done_q;
	logic [CNT_W-1:0]            pixel_total_q;
	logic [CNT_W-1:0]            mismatch_count_q;
	logic [CHAN_W-1:0]           peak_delta_q;
	logic [ABS_W-1:0]            abs_diff_sum_q;
	logic [SQ_W-1:0]             sq_diff_sum_q;
	logic [fdm_pkg::RATIO_W-1:0] mismatch_ratio_q;
	logic [fdm_pkg::Q8_W-1:0]    mean_abs_diff_q;
	logic [fdm_pkg::Q8_W-1:0]    rmse_q;

	assign dr = absdiff(actual_pixel[3*CHAN_W-1:2*CHAN_W], reference_pixel[3*CHAN_W-1:2*CHAN_W]);
	assign dg = absdiff(actual_pixel[2*CHAN_W-1:CHAN_W], reference_pixel[2*CHAN_W-1:CHAN_W]);
	assign db = absdiff(actual_pixel[CHAN_W-1:0], reference_pixel[CHAN_W-1:0]);

	assign sq_r = (2*CHAN_W)'(dr) * (2*CHAN_W)'(dr);
	assign sq_g = (2*CHAN_W)'(dg) * (2*CHAN_W)'(dg);
	assign sq_b = (2*CHAN_W)'(db) * (2*CHAN_W)'(db);

	assign px_sum = PSUM_W'(dr) + PSUM_W'(dg) + PSUM_W'(db);
	assign px_sq  = PSQ_W'(sq_r) + PSQ_W'(sq_g) + PSQ_W'(sq_b);
	assign m1     = (dr > dg) ? dr : dg;
	assign m2     = (m1 > db) ? m1 : db;
	assign room   = pix_cnt_q < CNT_W'(fdm_pkg::MAX_FRAME_PIXELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
			mis_cnt_q <= '0;
			max_q     <= '0;
			abs_acc_q <= '0;
			sq_acc_q  <= '0;
		end else if (cmd.frame_load) begin
			pix_cnt_q <= '0;
			mis_cnt_q <= '0;
			max_q     <= '0;
			abs_acc_q <= '0;
			sq_acc_q  <= '0;
		end else if (cmd.pix_take && room) begin
			pix_cnt_q <= pix_cnt_q + CNT_W'(1);
			if (px_sum != '0) begin
				mis_cnt_q <= mis_cnt_q + CNT_W'(1);
			end
			if (m2 > max_q) begin
				max_q <= m2;
			end
			abs_acc_q <= abs_acc_q + ABS_W'(px_sum);
			sq_acc_q  <= sq_acc_q + SQ_W'(px_sq);
		end
	end

	assign n3 = DEN_W'(pix_cnt_q) + {DEN_W'(pix_cnt_q) << 1};

	always_comb begin
		case (cmd.div_sel)
			fdm_pkg::DIV_RATIO: begin
				div_num = NUM_W'(mis_cnt_q) << fdm_pkg::RATIO_SHIFT;
				div_den = DEN_W'(pix_cnt_q);
			end
			fdm_pkg::DIV_MEAN: begin
				div_num = NUM_W'(abs_acc_q) << fdm_pkg::MEAN_SHIFT;
				div_den = n3;
			end
			fdm_pkg::DIV_RMS: begin
				div_num = NUM_W'(sq_acc_q) << fdm_pkg::RMS_SHIFT;
				div_den = n3;
			end
			default: begin
				div_num = '0;
				div_den = n3;
			end
		endcase
	end

	fdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	fdm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.rad    (div_quo),
		.root   (root),
		.done   (root_done)
	);

	assign stat.div_done  = div_done;
	assign stat.root_done = root_done;

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_sel)
				fdm_pkg::DIV_RATIO: ratio_q <= div_quo[fdm_pkg::RATIO_W-1:0];
				fdm_pkg::DIV_MEAN:  mean_q  <= div_quo[fdm_pkg::Q8_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_take) begin
			delta_argb_q <= {fdm_pkg::ALPHA_OPAQUE, dr, dg, db};
		end
		if (cmd.pix_take && !last_of_frame) begin
			frame_done_q       <= 1'b0;
			pixel_total_q      <= '0;
			mismatch_count_q   <= '0;
			peak_delta_q       <= '0;
			abs_diff_sum_q     <= '0;
			sq_diff_sum_q      <= '0;
			mismatch_ratio_q   <= '0;
			mean_abs_diff_q    <= '0;
			rmse_q             <= '0;
		end else if (cmd.frame_load) begin
			frame_done_q       <= 1'b1;
			pixel_total_q      <= pix_cnt_q;
			mismatch_count_q   <= mis_cnt_q;
			peak_delta_q       <= max_q;
			abs_diff_sum_q     <= abs_acc_q;
			sq_diff_sum_q      <= sq_acc_q;
			mismatch_ratio_q   <= ratio_q;
			mean_abs_diff_q    <= mean_q;
			rmse_q             <= root;
		end
	end

	assign delta_argb         = delta_argb_q;
	assign frame_done         = frame_done_q;
	assign pixel_total        = pixel_total_q;
	assign mismatch_count     = mismatch_count_q;
	assign peak_delta         = peak_delta_q;
	assign abs_diff_sum       = abs_diff_sum_q;
	assign sq_diff_sum        = sq_diff_sum_q;
	assign mismatch_ratio_q16 = mismatch_ratio_q;
	assign mean_abs_diff_q8   = mean_abs_diff_q;
	assign rmse_q8            = rmse_q;

endmodule

/* rtl/frame_difference_metrics.sv */
// Frame difference metrics, top level: pixel-pair input channel, result channel.
// Depends on fdm_pkg, fdm_ctrl and fdm_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) transfers one actual/reference RGB pixel pair
//   and a last_of_frame flag. Output channel (out_valid/out_ready) transfers one
//   result per pixel: the opaque ARGB absolute difference, plus, on the last pixel
//   of a frame, frame_done and the frame statistics (counts, max, sums, mismatch
//   ratio, mean absolute difference and RMSE).
//   Ordinary pixels: a result is valid the cycle after its transfer,
//   and a new pixel is taken while the previous result is being taken.
//   Last pixel of a frame: a shared one-bit-per-cycle divider runs three divisions
//   (ratio, mean, mean square), then the square-root unit runs; the result is
//   valid once the root is done, and no pixel is taken in between.
//   Accumulators then clear for the next frame; pixels past the frame limit
//   still produce a difference but are not counted.
//   Reset (arst_n low) clears accumulators, the sequencer and out_valid.
//   While out_valid is high and out_ready low, the result holds and in_ready
//   stays low.
module frame_difference_metrics (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fdm_pkg::PIX_W-1:0]      actual_pixel,
	input  logic [fdm_pkg::PIX_W-1:0]      reference_pixel,
	input  logic                           last_of_frame,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fdm_pkg::DIFF_W-1:0]     delta_argb,
	output logic                           frame_done,
	output logic [fdm_pkg::CNT_W-1:0]      pixel_total,
	output logic [fdm_pkg::CNT_W-1:0]      mismatch_count,
	output logic [fdm_pkg::CHAN_W-1:0]     peak_delta,
	output logic [fdm_pkg::ABS_W-1:0]      abs_diff_sum,
	output logic [fdm_pkg::SQ_W-1:0]       sq_diff_sum,
	output logic [fdm_pkg::RATIO_W-1:0]    mismatch_ratio_q16,
	output logic [fdm_pkg::Q8_W-1:0]       mean_abs_diff_q8,
	output logic [fdm_pkg::Q8_W-1:0]       rmse_q8
);

	fdm_pkg::fdm_cmd_t  cmd;
	fdm_pkg::fdm_stat_t stat;

	fdm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.last_of_frame (last_of_frame),
		.out_ready     (out_ready),
		.stat          (stat),
		.in_ready      (in_ready),
		.out_valid     (out_valid),
		.cmd           (cmd)
	);

	fdm_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.actual_pixel       (actual_pixel),
		.reference_pixel    (reference_pixel),
		.last_of_frame      (last_of_frame),
		.stat               (stat),
		.delta_argb         (delta_argb),
		.frame_done         (frame_done),
		.pixel_total        (pixel_total),
		.mismatch_count     (mismatch_count),
		.peak_delta         (peak_delta),
		.abs_diff_sum       (abs_diff_sum),
		.sq_diff_sum        (sq_diff_sum),
		.mismatch_ratio_q16 (mismatch_ratio_q16),
		.mean_abs_diff_q8   (mean_abs_diff_q8),
		.rmse_q8            (rmse_q8)
	);

endmodule
